// File: rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg: shared types and constants for the radial stick deadzone
// Widths of the radius, quotient and divider datapaths, plus step helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rsd_pkg;

  localparam int unsigned CENTER      = 127;
  localparam int unsigned SQ_W        = 16;  // ax^2 + ay^2
  localparam int unsigned ROOT_W      = 24;  // floor(sqrt(s * 2^32))
  localparam int unsigned REM_W       = 27;
  localparam int unsigned SQRT_STEPS  = 2;   // root bits per stage
  localparam int unsigned SQRT_STAGES = ROOT_W / SQRT_STEPS;
  localparam int unsigned DZ_W        = 16;
  localparam int unsigned NUM_W       = 64;
  localparam int unsigned DEN_W       = 48;
  localparam int unsigned DIV_W       = DEN_W + 1;
  localparam int unsigned Q_W         = 17;
  localparam int unsigned CMP_W       = DIV_W + Q_W;
  localparam int unsigned DIV_STAGES  = Q_W + 1;

  typedef struct packed {
    logic [7:0] ax;
    logic [7:0] ay;
    logic       neg_x;
    logic       neg_y;
    logic       nz;
  } rsd_side_t;

  typedef struct packed {
    logic neg;
    logic ok;
  } rsd_dside_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } rsd_sqrt_t;

  // Bit pair j (from the top) of the radicand s * 2^32.
  function automatic logic [1:0] sqrt_pair(input logic [SQ_W-1:0] s, input int j);
    logic [SQ_W-1:0] sh;
    sh = '0;
    if (j < SQ_W / 2) begin
      sh = s >> (SQ_W - 2 - 2 * j);
    end
    return sh[1:0];
  endfunction

  // One digit of the restoring square root.
  function automatic rsd_sqrt_t sqrt_step(input rsd_sqrt_t cur, input logic [1:0] pair);
    rsd_sqrt_t        nxt;
    logic [REM_W-1:0] remx;
    logic [REM_W-1:0] trial;
    remx  = {cur.rem[REM_W-3:0], pair};
    trial = {1'b0, cur.root, 2'b01};
    if (remx >= trial) begin
      nxt.rem  = remx - trial;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = remx;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rsd_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// rsd_sqrt_pipe: pipelined integer square root
// Computes floor(sqrt(s * 2^32)), two root bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_sqrt_pipe (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic [rsd_pkg::SQ_W-1:0]    s_i,
  input  wire rsd_pkg::rsd_side_t          side_i,
  output logic                             valid_o,
  output logic [rsd_pkg::ROOT_W-1:0]       root_o,
  output rsd_pkg::rsd_side_t               side_o
);

  localparam int unsigned NS = rsd_pkg::SQRT_STAGES;

  logic                     valid_q [NS];
  rsd_pkg::rsd_sqrt_t       st_q    [NS];
  logic [rsd_pkg::SQ_W-1:0] s_q     [NS];
  rsd_pkg::rsd_side_t       side_q  [NS];

  for (genvar p = 0; p < NS; p++) begin : g_stage
    logic                     valid_in;
    rsd_pkg::rsd_sqrt_t       st_in;
    logic [rsd_pkg::SQ_W-1:0] s_in;
    rsd_pkg::rsd_side_t       side_in;
    rsd_pkg::rsd_sqrt_t       st_d;

    if (p == 0) begin : g_first
      assign valid_in = valid_i;
      assign st_in    = '0;
      assign s_in     = s_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[p-1];
      assign st_in    = st_q[p-1];
      assign s_in     = s_q[p-1];
      assign side_in  = side_q[p-1];
    end

    always_comb begin
      st_d = st_in;
      for (int t = 0; t < int'(rsd_pkg::SQRT_STEPS); t++) begin
        st_d = rsd_pkg::sqrt_step(st_d,
          rsd_pkg::sqrt_pair(s_in, p * int'(rsd_pkg::SQRT_STEPS) + t));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[p] <= 1'b0;
      end else begin
        valid_q[p] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[p]   <= st_d;
      s_q[p]    <= s_in;
      side_q[p] <= side_in;
    end
  end

  assign valid_o = valid_q[NS-1];
  assign root_o  = st_q[NS-1].root;
  assign side_o  = side_q[NS-1];

endmodule

`default_nettype wire

// File: rtl/rsd_div_pipe.sv
// ----------------------------------------------------------------------------
// rsd_div_pipe: pipelined restoring divider
// One quotient bit per stage after the first; the first flags quotients that do not fit Q_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_div_pipe (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire logic [rsd_pkg::NUM_W-1:0]   num_i,
  input  wire logic [rsd_pkg::DIV_W-1:0]   div_i,
  input  wire rsd_pkg::rsd_dside_t         side_i,
  output logic                             valid_o,
  output logic [rsd_pkg::Q_W-1:0]          quo_o,
  output logic                             sat_o,
  output rsd_pkg::rsd_dside_t              side_o
);

  localparam int unsigned NS = rsd_pkg::DIV_STAGES;
  localparam int unsigned QW = rsd_pkg::Q_W;
  localparam int unsigned CW = rsd_pkg::CMP_W;
  localparam int unsigned NW = rsd_pkg::NUM_W;

  logic                      valid_q [NS];
  logic [NW-1:0]             rem_q   [NS];
  logic [rsd_pkg::DIV_W-1:0] div_q   [NS];
  logic [QW-1:0]             quo_q   [NS];
  logic                      sat_q   [NS];
  rsd_pkg::rsd_dside_t       side_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [NW-1:0] rem_d;
    logic [QW-1:0] quo_d;
    logic          sat_d;

    if (k == 0) begin : g_first
      // Saturate when the quotient reaches 2^Q_W.
      always_comb begin
        rem_d = num_i;
        quo_d = '0;
        sat_d = {{(CW-NW){1'b0}}, num_i} >= ({{QW{1'b0}}, div_i} << QW);
      end

      always_ff @(posedge clk_i) begin
        div_q[k]  <= div_i;
        side_q[k] <= side_i;
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[k] <= 1'b0;
        end else begin
          valid_q[k] <= valid_i;
        end
      end
    end else begin : g_next
      localparam int unsigned BIT = QW - k;
      logic [CW-1:0] shd;
      logic [CW-1:0] remx;

      always_comb begin
        shd   = {{QW{1'b0}}, div_q[k-1]} << BIT;
        remx  = {{(CW-NW){1'b0}}, rem_q[k-1]};
        rem_d = rem_q[k-1];
        quo_d = quo_q[k-1];
        sat_d = sat_q[k-1];
        if (remx >= shd) begin
          rem_d      = NW'(remx - shd);
          quo_d[BIT] = 1'b1;
        end
      end

      always_ff @(posedge clk_i) begin
        div_q[k]  <= div_q[k-1];
        side_q[k] <= side_q[k-1];
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[k] <= 1'b0;
        end else begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      quo_q[k] <= quo_d;
      sat_q[k] <= sat_d;
    end
  end

  assign valid_o = valid_q[NS-1];
  assign quo_o   = quo_q[NS-1];
  assign sat_o   = sat_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

`default_nettype wire

// File: rtl/radial_stick_deadzone.sv
// ----------------------------------------------------------------------------
// radial_stick_deadzone: radial scaled deadzone for one analog stick
// Throughput: one request per cycle; busy_o stays low, the pipeline never stalls.
// The receiver cannot stall: each result shows for one cycle with valid_o.
// Reset clears all valid bits and loads the deadzone with 0.25 (16384).
// ----------------------------------------------------------------------------
`default_nettype none

module radial_stick_deadzone (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [7:0]               raw_x_i,
  input  wire logic [7:0]               raw_y_i,
  input  wire logic                     deadzone_we_i,
  input  wire logic [rsd_pkg::DZ_W-1:0] deadzone_i,
  output logic                          valid_o,
  output logic signed [15:0]            axis_x_o,
  output logic signed [15:0]            axis_y_o,
  output logic                          deflected_o
);

  localparam logic [15:0] DZ_RESET = 16'd16384;

  // Deadzone register; the user must write it only while the pipeline is empty (not enforced here).
  logic [rsd_pkg::DZ_W-1:0] dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= DZ_RESET;
    end else if (deadzone_we_i) begin
      dz_q <= deadzone_i;
    end
  end

  // The pipeline takes a request every cycle.
  assign busy_o = 1'b0;

  // Stage A: center both axes, take magnitudes and the squared radius.
  logic                       acc;
  logic                       nx, ny;
  logic [7:0]                 ax, ay;
  logic [15:0]                sq_x, sq_y;
  logic                       a_valid_q;
  logic [rsd_pkg::SQ_W-1:0]   a_s_q;
  rsd_pkg::rsd_side_t         a_side_q;

  assign acc  = start_i && !busy_o;
  assign nx   = raw_x_i < 8'(rsd_pkg::CENTER);
  assign ny   = raw_y_i < 8'(rsd_pkg::CENTER);
  assign ax   = nx ? 8'(rsd_pkg::CENTER) - raw_x_i : raw_x_i - 8'(rsd_pkg::CENTER);
  assign ay   = ny ? 8'(rsd_pkg::CENTER) - raw_y_i : raw_y_i - 8'(rsd_pkg::CENTER);
  assign sq_x = ax * ax;
  assign sq_y = ay * ay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    a_s_q          <= sq_x + sq_y;
    a_side_q.ax    <= ax;
    a_side_q.ay    <= ay;
    a_side_q.neg_x <= nx;
    a_side_q.neg_y <= ny;
    a_side_q.nz    <= (ax != 8'd0) || (ay != 8'd0);
  end

  // Radius R in units of 1/(127 * 65536).
  logic                        r_valid;
  logic [rsd_pkg::ROOT_W-1:0]  r_root;
  rsd_pkg::rsd_side_t          r_side;

  rsd_sqrt_pipe u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (a_valid_q),
    .s_i     (a_s_q),
    .side_i  (a_side_q),
    .valid_o (r_valid),
    .root_o  (r_root),
    .side_o  (r_side)
  );

  // Stage B: deadzone test, excess radius and 127 * R.
  logic [22:0]                dz127;
  logic                       b_valid_q;
  logic                       b_ok_q;
  logic [rsd_pkg::ROOT_W-1:0] b_exc_q;
  logic [30:0]                b_r127_q;
  rsd_pkg::rsd_side_t         b_side_q;

  assign dz127 = {dz_q, 7'b0} - {7'b0, dz_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= r_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    b_ok_q   <= r_side.nz && (r_root >= {1'b0, dz127});
    b_exc_q  <= r_root - {1'b0, dz127};
    b_r127_q <= {r_root, 7'b0} - {7'b0, r_root};
    b_side_q <= r_side;
  end

  // Stage C: denominator and both scaled magnitudes.
  logic                       c_valid_q;
  logic                       c_ok_q;
  logic [rsd_pkg::DEN_W-1:0]  c_den_q;
  logic [31:0]                c_mx_q, c_my_q;
  rsd_pkg::rsd_side_t         c_side_q;
  logic [16:0]                one_minus_d;

  assign one_minus_d = 17'h10000 - {1'b0, dz_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_ok_q   <= b_ok_q;
    c_den_q  <= b_r127_q * one_minus_d;
    c_mx_q   <= b_side_q.ax * b_exc_q;
    c_my_q   <= b_side_q.ay * b_exc_q;
    c_side_q <= b_side_q;
  end

  // Stage D: round-to-nearest dividend 2*num + den and divisor 2*den.
  logic                       d_valid_q;
  logic [rsd_pkg::NUM_W-1:0]  d_nx_q, d_ny_q;
  logic [rsd_pkg::DIV_W-1:0]  d_div_q;
  rsd_pkg::rsd_dside_t        d_sx_q, d_sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_nx_q     <= {1'b0, c_mx_q, 31'b0} + {16'b0, c_den_q};
    d_ny_q     <= {1'b0, c_my_q, 31'b0} + {16'b0, c_den_q};
    d_div_q    <= {c_den_q, 1'b0};
    d_sx_q.neg <= c_side_q.neg_x;
    d_sx_q.ok  <= c_ok_q;
    d_sy_q.neg <= c_side_q.neg_y;
    d_sy_q.ok  <= c_ok_q;
  end

  logic                   qx_valid, qy_valid;
  logic [rsd_pkg::Q_W-1:0] qx, qy;
  logic                   qx_sat, qy_sat;
  rsd_pkg::rsd_dside_t    qx_side, qy_side;

  rsd_div_pipe u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid_q),
    .num_i   (d_nx_q),
    .div_i   (d_div_q),
    .side_i  (d_sx_q),
    .valid_o (qx_valid),
    .quo_o   (qx),
    .sat_o   (qx_sat),
    .side_o  (qx_side)
  );

  rsd_div_pipe u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid_q),
    .num_i   (d_ny_q),
    .div_i   (d_div_q),
    .side_i  (d_sy_q),
    .valid_o (qy_valid),
    .quo_o   (qy),
    .sat_o   (qy_sat),
    .side_o  (qy_side)
  );

  // Stage E: apply sign, saturate, zero inside the deadzone.
  function automatic logic [15:0] finish(input logic [rsd_pkg::Q_W-1:0] q,
                                         input logic sat, input rsd_pkg::rsd_dside_t sd);
    logic [15:0] v;
    if (!sd.ok) begin
      v = 16'd0;
    end else if (sd.neg) begin
      v = (sat || q > 17'd32768) ? 16'h8000 : 16'(~q + 17'd1);
    end else begin
      v = (sat || q > 17'd32767) ? 16'h7FFF : q[15:0];
    end
    return v;
  endfunction

  logic        e_valid_q;
  logic [15:0] ox, oy;
  logic [15:0] e_x_q, e_y_q;

  assign ox = finish(qx, qx_sat, qx_side);
  assign oy = finish(qy, qy_sat, qy_side);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else begin
      e_valid_q <= qx_valid && qy_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    e_x_q       <= ox;
    e_y_q       <= oy;
    deflected_o <= (ox != 16'd0) || (oy != 16'd0);
  end

  assign valid_o  = e_valid_q;
  assign axis_x_o = e_x_q;
  assign axis_y_o = e_y_q;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Radial stick deadzone testbench
// Drives stick sample requests and deadzone writes into the block, predicts
// every result with an integer model of the radial scaled deadzone and checks
// each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CENTER_RAW = 127;
  localparam int unsigned DRAIN_CYC  = 40;  // longer than the pipeline latency

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               defl;
  } stick_out_t;

  // Holds the deadzone copy, predicts sanitized axes and compares results.
  class deadzone_scoreboard;
    logic [15:0] deadzone;
    stick_out_t  pending[$];
    int          errors;

    function new();
      deadzone = 16'd16384;
      errors   = 0;
    endfunction

    // Integer square root, two radicand bits per iteration.
    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v    = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    // Scale one axis magnitude, round half away from zero, saturate Q2.14.
    function logic signed [15:0] scale_one(int unsigned mag, bit neg,
                                           longint unsigned excess,
                                           longint unsigned den);
      longint unsigned num;
      longint unsigned q;
      num = (longint'(mag) << 30) * excess;
      q   = (2 * num + den) / (2 * den);
      if (neg) return (q > 32768) ? 16'sh8000 : -$signed(q[15:0]);
      return (q > 32767) ? 16'sd32767 : $signed(q[15:0]);
    endfunction

    function void note_request(logic [7:0] rx, logic [7:0] ry);
      int              dx;
      int              dy;
      int unsigned     ax;
      int unsigned     ay;
      longint unsigned sq;
      longint unsigned rad;
      longint unsigned dz;
      stick_out_t      e;
      dx = int'(rx) - int'(CENTER_RAW);
      dy = int'(ry) - int'(CENTER_RAW);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      sq = longint'(ax) * ax + longint'(ay) * ay;
      rad = int_sqrt(sq << 32);
      dz = 127 * longint'(deadzone);
      e.x = 0;
      e.y = 0;
      // A centered stick and anything inside the deadzone give zeros.
      if (sq != 0 && rad >= dz) begin
        e.x = scale_one(ax, dx < 0, rad - dz, 127 * rad * (65536 - longint'(deadzone)));
        e.y = scale_one(ay, dy < 0, rad - dz, 127 * rad * (65536 - longint'(deadzone)));
      end
      e.defl = (e.x != 0) || (e.y != 0);
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [15:0] x, logic signed [15:0] y, logic d);
      stick_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d deflected=%0b", $time, x, y, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (x !== e.x) begin
        $display("%0t: axis_x expected %0d actual %0d", $time, e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $display("%0t: axis_y expected %0d actual %0d", $time, e.y, y);
        errors++;
      end
      if (d !== e.defl) begin
        $display("%0t: deflected expected %0b actual %0b", $time, e.defl, d);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [7:0]         raw_x_i;
  logic [7:0]         raw_y_i;
  logic               deadzone_we_i;
  logic [15:0]        deadzone_i;
  logic               valid_o;
  logic signed [15:0] axis_x_o;
  logic signed [15:0] axis_y_o;
  logic               deflected_o;

  deadzone_scoreboard sb = new();
  int unsigned        idle_pct;

  radial_stick_deadzone dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .raw_x_i      (raw_x_i),
    .raw_y_i      (raw_y_i),
    .deadzone_we_i(deadzone_we_i),
    .deadzone_i   (deadzone_i),
    .valid_o      (valid_o),
    .axis_x_o     (axis_x_o),
    .axis_y_o     (axis_y_o),
    .deflected_o  (deflected_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Sample results mid-cycle: the strobe and data are stable then and are
  // taken by the edge that ends the cycle.
  always @(negedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(axis_x_o, axis_y_o, deflected_o);
  end

  // Issue one request: raise start with data, then hold until an edge
  // finds busy low. Optionally idle at random first.
  task automatic send_request(logic [7:0] rx, logic [7:0] ry);
    int  gap;
    bit  was_busy;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    raw_x_i <= rx;
    raw_y_i <= ry;
    do begin
      @(negedge clk_i);
      was_busy = busy_o;
      @(posedge clk_i);
    end while (was_busy);
    sb.note_request(rx, ry);
  endtask

  // Drop start and wait until every predicted result is back, then let the
  // pipeline run empty.
  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // Write the deadzone while idle; the copy updates on the writing edge.
  task automatic write_deadzone(logic [15:0] val);
    drain();
    deadzone_we_i <= 1'b1;
    deadzone_i    <= val;
    @(posedge clk_i);
    sb.deadzone = val;
    deadzone_we_i <= 1'b0;
    deadzone_i    <= 16'($urandom());
  endtask

  // Mostly uniform samples, some near center to hover at the deadzone edge.
  task automatic random_request();
    if ($urandom_range(3) == 0)
      send_request(8'(CENTER_RAW - 12 + $urandom_range(24)),
                   8'(CENTER_RAW - 12 + $urandom_range(24)));
    else
      send_request(8'($urandom()), 8'($urandom()));
  endtask

  initial begin
    logic [15:0] dz_list[6];
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    raw_x_i       = '0;
    raw_y_i       = '0;
    deadzone_we_i = 1'b0;
    deadzone_i    = '0;
    idle_pct      = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset deadzone of 0.25, centered stick, inside zone, corners.
    send_request(8'd127, 8'd127);
    send_request(8'd128, 8'd127);
    send_request(8'd126, 8'd127);
    send_request(8'd140, 8'd120);
    send_request(8'd0,   8'd0);
    send_request(8'd255, 8'd255);
    send_request(8'd0,   8'd255);
    send_request(8'd255, 8'd0);
    send_request(8'd127, 8'd0);
    send_request(8'd127, 8'd255);
    send_request(8'd0,   8'd127);
    send_request(8'd255, 8'd127);
    // Zero deadzone: a centered stick still gives zeros.
    write_deadzone(16'd0);
    send_request(8'd127, 8'd127);
    send_request(8'd128, 8'd128);
    send_request(8'd0,   8'd255);
    send_request(8'd255, 8'd127);
    // Largest deadzone: diagonals far out saturate both ways.
    write_deadzone(16'hFFFF);
    send_request(8'd0,   8'd0);
    send_request(8'd255, 8'd255);
    send_request(8'd0,   8'd255);
    send_request(8'd127, 8'd0);
    send_request(8'd200, 8'd50);

    // Random phases: sender idles 30%, then 48%, then never.
    dz_list = '{16'h0000, 16'($urandom()), 16'hFFFF, 16'h8000, 16'($urandom()),
                16'hC000};
    for (int ph = 0; ph < 6; ph++) begin
      write_deadzone(dz_list[ph]);
      idle_pct = (ph < 2) ? 30 : (ph < 4) ? 48 : 0;
      for (int i = 0; i < 190; i++) begin
        // Hold off once mid-phase until every result is back.
        if (ph == 3 && i == 95) drain();
        random_request();
      end
    end

    drain();
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
